/* hdl/prcf_pkg.sv */
`default_nettype none
package prcf_pkg;

	typedef logic [31:0] word_t;
	typedef logic [9:0]  count_t;
	typedef logic [10:0] pos_t;
	typedef logic [2:0]  emit_t;
	typedef logic [1:0]  cfg_idx_t;
	typedef logic [15:0] cfg_data_t;

	typedef enum logic [1:0] {
		KIND_HEADER = 2'd0,
		KIND_VALUE  = 2'd1,
		KIND_CRC    = 2'd2,
		KIND_STATUS = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_BAD_MAGIC   = 3'd1,
		ST_BAD_VERSION = 3'd2,
		ST_BAD_COUNT   = 3'd3,
		ST_CRC_MISMATCH = 3'd4
	} status_t;

	localparam cfg_idx_t CFG_MODE  = 2'd0;
	localparam cfg_idx_t CFG_COUNT = 2'd1;

	localparam logic MODE_CHECK = 1'b0;
	localparam logic MODE_BUILD = 1'b1;

	localparam word_t  REC_MAGIC   = 32'h4650_4152;
	localparam word_t  REC_VERSION = 32'h0000_0001;
	localparam word_t  CRC_POLY    = 32'hEDB8_8320;
	localparam word_t  CRC_INIT    = 32'hFFFF_FFFF;
	localparam count_t COUNT_RESET = 10'd69;
	localparam emit_t  HDR_WORDS   = 3'd3;

	// 32 shift steps on a constant: only evaluated for unit vectors
	function automatic word_t crc_shift32(word_t x);
		word_t r;
		r = x;
		for (int b = 0; b < 32; b++) begin
			r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		end
		return r;
	endfunction

	// fold one word: XOR of the constant columns selected by crc ^ data
	function automatic word_t crc_word(word_t crc, word_t data);
		word_t x;
		word_t r;
		x = crc ^ data;
		r = '0;
		for (int i = 0; i < 32; i++) begin
			if (x[i]) begin
				r = r ^ crc_shift32(word_t'(1) << i);
			end
		end
		return r;
	endfunction

	localparam word_t CRC_AFTER_VER = crc_word(crc_word(CRC_INIT, REC_MAGIC), REC_VERSION);

endpackage
`default_nettype wire

/* hdl/prcf_in_if.sv */
`default_nettype none
interface prcf_in_if;
	logic              valid;
	logic              ready;
	prcf_pkg::word_t   in_word;

	modport source (output valid, output in_word, input ready);
	modport sink   (input valid, input in_word, output ready);
endinterface
`default_nettype wire

/* hdl/prcf_out_if.sv */
`default_nettype none
interface prcf_out_if;
	logic              valid;
	logic              ready;
	prcf_pkg::word_t   out_word;
	logic [1:0]        out_kind;
	logic [2:0]        status;
	logic              last_of_record;

	modport source (output valid, output out_word, output out_kind, output status,
		output last_of_record, input ready);
	modport sink   (input valid, input out_word, input out_kind, input status,
		input last_of_record, output ready);
endinterface
`default_nettype wire

/* hdl/prcf_cfg_if.sv */
`default_nettype none
interface prcf_cfg_if;
	logic                 valid;
	logic                 ready;
	prcf_pkg::cfg_idx_t   index;
	prcf_pkg::cfg_data_t  data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* hdl/param_record_crc_frame.sv */
// channel   modport  payload                                     transfer when
// words     sink     in_word[31:0]                               valid & ready
// results   source   out_word[31:0] out_kind[1:0] status[2:0]    valid & ready
//                    last_of_record
// cfg       sink     index[1:0] data[15:0] (0 mode, 1 count)     valid & ready (ready = 1)
//
// One word enters per cycle while the input register is free; it is held there and
// emits its results through one output register, one result per cycle.
// Most words give one result, check-mode header words none; the first word of a built
// record gives three header words, its value and, if also last, the CRC; the last word
// of a longer built record gives value and CRC, all through the single output port.
// Reset: check mode, count 69, position 0, CRC all ones, no error. Any cfg write restarts.
// Output stalls hold the input register, and words stall behind it.
`default_nettype none
module param_record_crc_frame (
	input  wire logic clk,
	input  wire logic arst_n,
	prcf_in_if.sink   words,
	prcf_out_if.source results,
	prcf_cfg_if.sink  cfg
);
	import prcf_pkg::*;

	logic    mode_q;
	count_t  count_q;
	pos_t    pos_q;
	word_t   crc_q;
	status_t err_q;
	word_t   hdr_crc_q;

	logic    valid_s1;
	word_t   word_s1;
	emit_t   idx_q;

	logic    out_valid_q;
	word_t   out_word_q;
	kind_t   out_kind_q;
	status_t out_status_q;
	logic    out_last_q;

	count_t  n;
	pos_t    n_ext;
	logic    in_body;
	logic    build_last;
	word_t   crc_in;
	word_t   crc_nx;
	emit_t   res_cnt;
	emit_t   hdr_cnt;
	logic    out_free;
	logic    emit;
	logic    done;
	logic    cfg_wr;
	logic    take;

	word_t   res_word;
	kind_t   res_kind;
	status_t res_status;
	logic    res_last;
	status_t chk_status;
	status_t err_nx;

	assign cfg_wr    = cfg.valid && cfg.ready;
	assign cfg.ready = 1'b1;

	assign n          = (count_q == '0) ? count_t'(1) : count_q;
	assign n_ext      = pos_t'(n);
	assign in_body    = pos_q < (n_ext + pos_t'(3));
	assign build_last = (pos_q + pos_t'(1)) >= n_ext;
	assign hdr_cnt    = (pos_q == '0) ? HDR_WORDS : emit_t'(0);

	assign crc_in = (mode_q == MODE_BUILD && pos_q == '0) ? hdr_crc_q : crc_q;
	assign crc_nx = crc_word(crc_in, word_s1);

	assign chk_status = (err_q != ST_OK) ? err_q :
		((word_s1 != ~crc_q) ? ST_CRC_MISMATCH : ST_OK);

	always_comb begin
		err_nx = err_q;
		if (err_q == ST_OK) begin
			if (pos_q == pos_t'(0) && word_s1 != REC_MAGIC) begin
				err_nx = ST_BAD_MAGIC;
			end else if (pos_q == pos_t'(1) && word_s1 != REC_VERSION) begin
				err_nx = ST_BAD_VERSION;
			end else if (pos_q == pos_t'(2) && word_s1 != word_t'(n)) begin
				err_nx = ST_BAD_COUNT;
			end
		end
	end

	always_comb begin
		res_word   = word_s1;
		res_kind   = KIND_VALUE;
		res_status = ST_OK;
		res_last   = 1'b0;
		if (mode_q == MODE_CHECK) begin
			res_cnt = (!in_body || pos_q >= pos_t'(3)) ? emit_t'(1) : emit_t'(0);
			if (!in_body) begin
				res_word   = '0;
				res_kind   = KIND_STATUS;
				res_status = chk_status;
				res_last   = 1'b1;
			end
		end else begin
			res_cnt = hdr_cnt + emit_t'(1) + emit_t'(build_last);
			if (idx_q < hdr_cnt) begin
				res_kind = KIND_HEADER;
				case (idx_q[1:0])
					2'd0:    res_word = REC_MAGIC;
					2'd1:    res_word = REC_VERSION;
					default: res_word = word_t'(n);
				endcase
			end else if (idx_q != hdr_cnt) begin
				res_word = ~crc_nx;
				res_kind = KIND_CRC;
				res_last = 1'b1;
			end
		end
	end

	assign out_free    = !out_valid_q || results.ready;
	assign emit        = valid_s1 && res_cnt != '0 && out_free;
	assign done        = valid_s1 && (res_cnt == '0 || (emit && idx_q == res_cnt - emit_t'(1)));
	assign words.ready = !valid_s1 || done;
	assign take        = words.valid && words.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_CHECK;
			count_q     <= COUNT_RESET;
			pos_q       <= '0;
			crc_q       <= CRC_INIT;
			err_q       <= ST_OK;
			valid_s1    <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (done) begin
				valid_s1 <= 1'b0;
			end
			if (done) begin
				idx_q <= '0;
			end else if (emit) begin
				idx_q <= idx_q + emit_t'(1);
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end

			if (cfg_wr) begin
				if (cfg.index == CFG_MODE) begin
					mode_q <= cfg.data[0];
				end else if (cfg.index == CFG_COUNT) begin
					count_q <= count_t'(cfg.data[9:0]);
				end
				pos_q <= '0;
				crc_q <= CRC_INIT;
				err_q <= ST_OK;
			end else if (done) begin
				if (mode_q == MODE_CHECK) begin
					if (in_body) begin
						err_q <= err_nx;
						crc_q <= crc_nx;
						pos_q <= pos_q + pos_t'(1);
					end else begin
						pos_q <= '0;
						crc_q <= CRC_INIT;
						err_q <= ST_OK;
					end
				end else begin
					if (build_last) begin
						pos_q <= '0;
						crc_q <= CRC_INIT;
						err_q <= ST_OK;
					end else begin
						crc_q <= crc_nx;
						pos_q <= pos_q + pos_t'(1);
					end
				end
			end
		end
	end

	// header CRC follows the count; it is registered from count_q, so it settles after count_q
	always_ff @(posedge clk) begin
		hdr_crc_q <= crc_word(CRC_AFTER_VER, word_t'(n));
		if (take) begin
			word_s1 <= words.in_word;
		end
		if (emit) begin
			out_word_q   <= res_word;
			out_kind_q   <= res_kind;
			out_status_q <= res_status;
			out_last_q   <= res_last;
		end
	end

	assign results.valid          = out_valid_q;
	assign results.out_word       = out_word_q;
	assign results.out_kind       = out_kind_q;
	assign results.status         = out_status_q;
	assign results.last_of_record = out_last_q;

	a_emit_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= emit_t'(4))
		else $error("emit index beyond five results");

	a_cfg_restart: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr |=> (pos_q == '0 && err_q == ST_OK && crc_q == CRC_INIT))
		else $error("cfg write did not restart the record");

	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_kind_q == KIND_STATUS) |->
		(out_last_q && out_word_q == '0))
		else $error("status result not closing the record");

	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(err_q != ST_OK && !cfg_wr && !(done && (!in_body || build_last)))
		|=> err_q == $past(err_q))
		else $error("first error overwritten");

endmodule
`default_nettype wire
